FILE: hdl/json_bracket_balance_checker_assert.svh
// Assertion macros for the bracket balance checker.
// Each expects clk and arst_n in scope.
`ifndef JSON_BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define JSON_BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define JBBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define JBBC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/jbbc_pkg.sv
package jbbc_pkg;

	// Width of the byte counter and of the nesting depth.
	localparam int CountBits = 21;
	// Width of the max_length register.
	localparam int LenBits = 21;
	// Width used to compare count against max_length.
	localparam int CmpBits = (CountBits > LenBits) ? CountBits : LenBits;

	localparam logic [CountBits-1:0] CountMax = '1;
	localparam logic [LenBits-1:0] MaxLenReset = LenBits'(1024 * 1024);

	// Configuration register indexes.
	localparam int CfgIndexBits = 2;
	localparam logic [CfgIndexBits-1:0] CfgCheckEnable = 2'd0;
	localparam logic [CfgIndexBits-1:0] CfgMaxLength = 2'd1;

	// Payload bytes of interest.
	localparam logic [7:0] ChOpenBrace = 8'h7B;
	localparam logic [7:0] ChOpenBracket = 8'h5B;
	localparam logic [7:0] ChCloseBrace = 8'h7D;
	localparam logic [7:0] ChCloseBracket = 8'h5D;
	localparam logic [7:0] ChComma = 8'h2C;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChLf = 8'h0A;
	localparam logic [7:0] ChCr = 8'h0D;

	typedef enum logic [2:0] {
		StOk = 3'd0,
		StTooLong = 3'd1,
		StTrailComma = 3'd2,
		StUnexpClose = 3'd3,
		StUnclosed = 3'd4
	} status_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChCr);
	endfunction

endpackage

FILE: hdl/json_bracket_balance_checker.sv
// Bracket balance checker for a text payload, one byte per transfer.
// Input channel: byte_valid / byte_stall with data_byte and last_byte; the
// last byte of a payload carries last_byte = 1. Output channel:
// status_valid / status_stall with one status per payload (0 ok, 1 too
// long, 2 trailing comma, 3 unexpected close, 4 unclosed), given only for
// the last byte. Configuration: cfg_we writes cfg_data into the register at
// cfg_index (0 check_enable, 1 max_length); write only while idle.
// Pipeline: a byte is registered at its transfer in the input register and
// the per-byte update runs from there, loading the status register at the
// same edge as the payload state.
// Throughput: one byte per cycle, except while a last byte is stalled; the
// depth/string/count update loop sets that figure.
// Reset: clears the payload state and the pipeline, check_enable returns to
// 1 and max_length to 1048576.
// Stall: while the status register is full and stalled, a last byte waits
// in the input register and byte_stall is raised; other bytes keep flowing.
`include "json_bracket_balance_checker_assert.svh"

module json_bracket_balance_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	output logic                                status_valid,
	input  logic                                status_stall,
	output logic [2:0]                          status,
	input  logic                                cfg_we,
	input  logic [jbbc_pkg::CfgIndexBits-1:0]   cfg_index,
	input  logic [jbbc_pkg::LenBits-1:0]        cfg_data
);

	// Configuration
	logic                           check_enable_q;
	logic [jbbc_pkg::LenBits-1:0]   max_length_q;

	// Input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Payload state
	logic [jbbc_pkg::CountBits-1:0] nest_depth_q;
	logic                           inside_string_q;
	logic                           escape_pending_q;
	logic                           prev_was_comma_q;
	logic [jbbc_pkg::CountBits-1:0] byte_count_q;
	jbbc_pkg::status_t              first_error_q;

	// Output register
	logic              status_valid_q;
	jbbc_pkg::status_t status_q;

	// Next-state values
	logic [jbbc_pkg::CountBits-1:0] depth_d;
	logic                           instr_d;
	logic                           esc_d;
	logic                           comma_d;
	logic [jbbc_pkg::CountBits-1:0] count_d;
	jbbc_pkg::status_t              err_d;
	jbbc_pkg::status_t              status_d;

	logic out_free;
	logic adv;
	logic accept;

	assign out_free = !status_valid_q || !status_stall;
	assign adv = valid_s1 && (!last_s1 || out_free);
	assign byte_stall = valid_s1 && !adv;
	assign accept = byte_valid && !byte_stall;

	assign status_valid = status_valid_q;
	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= 1'b1;
			max_length_q <= jbbc_pkg::MaxLenReset;
		end else if (cfg_we) begin
			if (cfg_index == jbbc_pkg::CfgCheckEnable) begin
				check_enable_q <= cfg_data[0];
			end else if (cfg_index == jbbc_pkg::CfgMaxLength) begin
				max_length_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		logic comma_before;
		logic is_open;
		logic is_close;

		comma_before = prev_was_comma_q;
		is_open = (data_s1 == jbbc_pkg::ChOpenBrace) || (data_s1 == jbbc_pkg::ChOpenBracket);
		is_close = (data_s1 == jbbc_pkg::ChCloseBrace) || (data_s1 == jbbc_pkg::ChCloseBracket);

		depth_d = nest_depth_q;
		instr_d = inside_string_q;
		esc_d = escape_pending_q;
		comma_d = prev_was_comma_q;
		err_d = first_error_q;
		count_d = (byte_count_q == jbbc_pkg::CountMax) ? byte_count_q
			: byte_count_q + jbbc_pkg::CountBits'(1);

		// Bracket and string tracking stops once an error is latched; the byte count keeps running.
		if (first_error_q == jbbc_pkg::StOk) begin
			if (!jbbc_pkg::is_space(data_s1)) begin
				comma_d = (data_s1 == jbbc_pkg::ChComma);
			end
			priority if (escape_pending_q) begin
				esc_d = 1'b0;
			end else if (data_s1 == jbbc_pkg::ChBackslash && inside_string_q) begin
				esc_d = 1'b1;
			end else if (data_s1 == jbbc_pkg::ChQuote) begin
				instr_d = !inside_string_q;
			end else if (!inside_string_q && is_open) begin
				if (nest_depth_q != jbbc_pkg::CountMax) begin
					depth_d = nest_depth_q + jbbc_pkg::CountBits'(1);
				end
			end else if (!inside_string_q && is_close) begin
				priority if (comma_before) begin
					err_d = jbbc_pkg::StTrailComma;
				end else if (nest_depth_q == '0) begin
					err_d = jbbc_pkg::StUnexpClose;
				end else begin
					depth_d = nest_depth_q - jbbc_pkg::CountBits'(1);
				end
			end else begin
				// Plain text or string contents: hold the depth.
				depth_d = nest_depth_q;
			end
		end

		priority if (jbbc_pkg::CmpBits'(count_d) > jbbc_pkg::CmpBits'(max_length_q)) begin
			status_d = jbbc_pkg::StTooLong;
		end else if (!check_enable_q) begin
			status_d = jbbc_pkg::StOk;
		end else if (err_d != jbbc_pkg::StOk) begin
			status_d = err_d;
		end else if (depth_d != '0) begin
			status_d = jbbc_pkg::StUnclosed;
		end else begin
			status_d = jbbc_pkg::StOk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nest_depth_q <= '0;
			inside_string_q <= 1'b0;
			escape_pending_q <= 1'b0;
			prev_was_comma_q <= 1'b0;
			byte_count_q <= '0;
			first_error_q <= jbbc_pkg::StOk;
		end else if (adv) begin
			if (last_s1) begin
				// Clear for the next payload.
				nest_depth_q <= '0;
				inside_string_q <= 1'b0;
				escape_pending_q <= 1'b0;
				prev_was_comma_q <= 1'b0;
				byte_count_q <= '0;
				first_error_q <= jbbc_pkg::StOk;
			end else begin
				nest_depth_q <= depth_d;
				inside_string_q <= instr_d;
				escape_pending_q <= esc_d;
				prev_was_comma_q <= comma_d;
				byte_count_q <= count_d;
				first_error_q <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			status_valid_q <= 1'b1;
		end else if (!status_stall) begin
			status_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status_q <= status_d;
		end
	end

	`JBBC_ASSERT(a_status_from_last, $rose(status_valid_q) |-> $past(adv && last_s1), "status raised without a last byte")
	`JBBC_ASSERT(a_stall_cause, byte_stall |-> (valid_s1 && last_s1 && status_valid_q && status_stall), "input stalled without a full stalled status")
	`JBBC_ASSERT(a_clear_after_last, (adv && last_s1) |=> (byte_count_q == '0 && nest_depth_q == '0 && first_error_q == jbbc_pkg::StOk), "payload state not cleared after last byte")
	`JBBC_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!status_valid_q && !valid_s1), "pipeline not empty in reset")

endmodule
